>>> hdl/swq_pkg.sv
package swq_pkg;

  localparam int unsigned MaxProcs = 32;
  localparam int unsigned IdxW = $clog2(MaxProcs);

  typedef enum logic [2:0] {
    OP_BLOCK   = 3'd0,
    OP_DEQUEUE = 3'd1,
    OP_RM_SLOT = 3'd2,
    OP_RM_PID  = 3'd3,
    OP_PEEK    = 3'd4,
    OP_NOP     = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] sem_key;
    logic [4:0]  proc_slot;
    logic [30:0] proc_pid;
  } swq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  out_slot;
    logic [30:0] out_pid;
    logic [31:0] out_key;
  } swq_out_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic [2:0]      opcode;
    logic            hit;
    logic [IdxW-1:0] idx;
    logic            free_ok;
    logic [IdxW-1:0] free_idx;
    logic [IdxW-1:0] slot;
    logic [31:0]     sem_key;
    logic [30:0]     proc_pid;
  } swq_cmd_t;

endpackage

>>> hdl/semaphore_wait_queue_table_top.sv
// Semaphore wait-queue table. One command is accepted when start_i is high and busy_o low;
// key, pid and free-descriptor compares are done combinationally before acceptance. The
// result appears on result_o for exactly one cycle with done_o after the classified command
// is registered in the front part, handed over to the back part, then taken through a
// pointer read and a pointer write. busy_o stays high from acceptance until the result
// cycle; the next command can be accepted at the edge ending the result cycle, so no two
// commands overlap. The receiver cannot stall; results must be taken in the strobe cycle.
module semaphore_wait_queue_table_top
  import swq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  swq_in_t  cmd_i,
  output logic     busy_o,
  output logic     done_o,
  output swq_out_t result_o
);

  logic                 cmd_valid, idle, pend_q;
  swq_cmd_t             cmd;
  logic [MaxProcs-1:0]  dvalid, blocked;
  logic [MaxProcs-1:0][31:0] dkey;
  logic [MaxProcs-1:0][30:0] pids;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (start_i && !busy_o) begin
      pend_q <= 1'b1;
    end else if (done_o) begin
      pend_q <= 1'b0;
    end
  end

  assign busy_o = pend_q && !done_o || !idle;

  swq_front u_front (
    .clk_i, .rst_ni, .start_i, .in_i(cmd_i), .busy_i(busy_o),
    .desc_valid_i(dvalid), .desc_key_i(dkey), .proc_blocked_i(blocked),
    .proc_pid_i(pids), .cmd_valid_o(cmd_valid), .cmd_o(cmd)
  );

  swq_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .idle_o(idle),
    .desc_valid_o(dvalid), .desc_key_o(dkey), .proc_blocked_o(blocked),
    .proc_pid_o(pids), .done_o, .res_o(result_o)
  );

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted command not busy");
  a_done_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pend_q) else $error("result without command");
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.status != 2'd3) else $error("bad status");
`endif

endmodule

>>> hdl/swq_front.sv
module swq_front
  import swq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  swq_in_t              in_i,
  input  logic                 busy_i,
  input  logic [MaxProcs-1:0]  desc_valid_i,
  input  logic [MaxProcs-1:0][31:0] desc_key_i,
  input  logic [MaxProcs-1:0]  proc_blocked_i,
  input  logic [MaxProcs-1:0][30:0] proc_pid_i,
  output logic                 cmd_valid_o,
  output swq_cmd_t             cmd_o
);

  swq_cmd_t cmd_d, cmd_q;
  logic     vld_q;
  logic     key_hit, pid_hit, free_ok, slot_ok;
  logic [IdxW-1:0] key_idx, pid_idx, free_idx;

  always_comb begin
    key_hit = 1'b0; key_idx = '0;
    pid_hit = 1'b0; pid_idx = '0;
    free_ok = 1'b0; free_idx = '0;
    for (int i = MaxProcs - 1; i >= 0; i--) begin
      if (desc_valid_i[i] && desc_key_i[i] == in_i.sem_key) begin
        key_hit = 1'b1; key_idx = IdxW'(i);
      end
      if (proc_blocked_i[i] && proc_pid_i[i] == in_i.proc_pid) begin
        pid_hit = 1'b1; pid_idx = IdxW'(i);
      end
      if (!desc_valid_i[i]) begin
        free_ok = 1'b1; free_idx = IdxW'(i);
      end
    end
    slot_ok = ({27'd0, in_i.proc_slot} < 32'(MaxProcs));
    cmd_d = '0;
    cmd_d.opcode   = in_i.opcode;
    cmd_d.sem_key  = in_i.sem_key;
    cmd_d.proc_pid = in_i.proc_pid;
    cmd_d.slot     = IdxW'(in_i.proc_slot);
    cmd_d.free_ok  = free_ok;
    cmd_d.free_idx = free_idx;
    case (in_i.opcode)
      OP_BLOCK: begin
        cmd_d.hit = key_hit; cmd_d.idx = key_idx;
        cmd_d.free_ok = free_ok && slot_ok;
        if (!slot_ok || proc_blocked_i[IdxW'(in_i.proc_slot)]) begin
          cmd_d.opcode = OP_NOP;
        end
      end
      OP_DEQUEUE, OP_PEEK: begin
        cmd_d.hit = key_hit; cmd_d.idx = key_idx;
      end
      OP_RM_SLOT: begin
        cmd_d.hit = slot_ok && proc_blocked_i[IdxW'(in_i.proc_slot)];
        cmd_d.idx = IdxW'(in_i.proc_slot);
      end
      OP_RM_PID: begin
        cmd_d.hit = pid_hit; cmd_d.idx = pid_idx;
      end
      default: cmd_d.hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i && !busy_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_i) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

>>> hdl/swq_back.sv
module swq_back
  import swq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  swq_cmd_t             cmd_i,
  output logic                 idle_o,
  output logic [MaxProcs-1:0]  desc_valid_o,
  output logic [MaxProcs-1:0][31:0] desc_key_o,
  output logic [MaxProcs-1:0]  proc_blocked_o,
  output logic [MaxProcs-1:0][30:0] proc_pid_o,
  output logic                 done_o,
  output swq_out_t             res_o
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE} state_e;

  state_e state_q;
  swq_cmd_t c_q;
  logic [MaxProcs-1:0] dvalid_q, blocked_q;
  logic [MaxProcs-1:0][31:0] dkey_q;
  logic [MaxProcs-1:0][30:0] pid_q;
  logic [IdxW-1:0] dhead_q [MaxProcs];
  logic [IdxW-1:0] dtail_q [MaxProcs];
  logic [IdxW-1:0] pdesc_q [MaxProcs];
  logic [IdxW-1:0] pnext_q [MaxProcs];
  logic [IdxW-1:0] pprev_q [MaxProcs];
  logic [IdxW-1:0] s_q, d_q, tl_q;
  logic done_q;
  swq_out_t res_d, res_q;

  always_comb begin
    res_d = '0;
    res_d.status = ST_NONE;
    case (c_q.opcode)
      OP_BLOCK: begin
        res_d.status = (!c_q.hit && !c_q.free_ok) ? ST_FULL : ST_OK;
      end
      OP_DEQUEUE, OP_PEEK, OP_RM_SLOT, OP_RM_PID: begin
        if (c_q.hit) begin
          res_d.status   = ST_OK;
          res_d.out_slot = 5'(s_q);
          res_d.out_pid  = pid_q[s_q];
          res_d.out_key  = dkey_q[d_q];
        end
      end
      default: res_d.status = ST_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      dvalid_q  <= '0;
      blocked_q <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= (state_q == S_WRITE);
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            c_q     <= cmd_i;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_WRITE;
          if (c_q.opcode == OP_BLOCK) begin
            d_q  <= c_q.hit ? c_q.idx : c_q.free_idx;
            tl_q <= dtail_q[c_q.idx];
            s_q  <= c_q.slot;
          end else begin
            if (c_q.opcode == OP_DEQUEUE || c_q.opcode == OP_PEEK) begin
              s_q <= dhead_q[c_q.idx];
              d_q <= c_q.idx;
            end else begin
              s_q <= c_q.idx;
              d_q <= pdesc_q[c_q.idx];
            end
          end
        end
        S_WRITE: begin
          state_q <= S_IDLE;
          res_q   <= res_d;
          case (c_q.opcode)
            OP_BLOCK: begin
              if (c_q.hit || c_q.free_ok) begin
                if (!c_q.hit) begin
                  dvalid_q[d_q] <= 1'b1;
                  dkey_q[d_q]   <= c_q.sem_key;
                  dhead_q[d_q]  <= s_q;
                end else begin
                  pnext_q[tl_q] <= s_q;
                  pprev_q[s_q]  <= tl_q;
                end
                dtail_q[d_q]   <= s_q;
                blocked_q[s_q] <= 1'b1;
                pdesc_q[s_q]   <= d_q;
                pid_q[s_q]     <= c_q.proc_pid;
              end
            end
            OP_DEQUEUE, OP_RM_SLOT, OP_RM_PID: begin
              if (c_q.hit) begin
                blocked_q[s_q] <= 1'b0;
                if (dhead_q[d_q] == s_q && dtail_q[d_q] == s_q) begin
                  dvalid_q[d_q] <= 1'b0;
                end else if (dhead_q[d_q] == s_q) begin
                  dhead_q[d_q] <= pnext_q[s_q];
                end else if (dtail_q[d_q] == s_q) begin
                  dtail_q[d_q] <= pprev_q[s_q];
                end else begin
                  pnext_q[pprev_q[s_q]] <= pnext_q[s_q];
                  pprev_q[pnext_q[s_q]] <= pprev_q[s_q];
                end
              end
            end
            default: ;
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign idle_o         = (state_q == S_IDLE) && !cmd_valid_i;
  assign desc_valid_o   = dvalid_q;
  assign desc_key_o     = dkey_q;
  assign proc_blocked_o = blocked_q;
  assign proc_pid_o     = pid_q;
  assign done_o         = done_q;
  assign res_o          = res_q;

endmodule

>>> test/semaphore_wait_queue_table_top_tb.sv
module semaphore_wait_queue_table_top_tb;
  import swq_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandomItems = 1900;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  swq_in_t  cmd_i;
  logic     busy_o;
  logic     done_o;
  swq_out_t result_o;

  semaphore_wait_queue_table_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  class wait_queue_scoreboard;
    bit              sem_used [MaxProcs];
    logic [31:0]     sem_key_tab [MaxProcs];
    logic [IdxW-1:0] sem_head [MaxProcs];
    logic [IdxW-1:0] sem_tail [MaxProcs];
    bit              waiting [MaxProcs];
    logic [IdxW-1:0] waits_on [MaxProcs];
    logic [IdxW-1:0] link_next [MaxProcs];
    logic [IdxW-1:0] link_prev [MaxProcs];
    logic [30:0]     pid_of [MaxProcs];
    swq_out_t        pending_results[$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     ok_count;

    function new();
      foreach (sem_used[i]) begin
        sem_used[i] = 0;
        waiting[i] = 0;
      end
      mismatches = 0;
      checked = 0;
      ok_count = 0;
    endfunction

    function int lookup_key(logic [31:0] key);
      for (int d = 0; d < MaxProcs; d++)
        if (sem_used[d] && sem_key_tab[d] == key) return d;
      return -1;
    endfunction

    function void detach(int s);
      int d;
      bit at_head;
      bit at_tail;
      d = int'(waits_on[s]);
      at_head = (sem_head[d] == IdxW'(s));
      at_tail = (sem_tail[d] == IdxW'(s));
      if (at_head && at_tail) begin
        sem_used[d] = 0;
      end else if (at_head) begin
        sem_head[d] = link_next[s];
      end else if (at_tail) begin
        sem_tail[d] = link_prev[s];
      end else begin
        link_next[link_prev[s]] = link_next[s];
        link_prev[link_next[s]] = link_prev[s];
      end
      waiting[s] = 0;
    endfunction

    function swq_out_t granted(int s);
      swq_out_t r;
      r.status = ST_OK;
      r.out_slot = 5'(s);
      r.out_pid = pid_of[s];
      r.out_key = sem_key_tab[waits_on[s]];
      return r;
    endfunction

    function void note_transfer(swq_in_t c);
      swq_out_t r;
      int d;
      int s;
      r = '0;
      r.status = ST_NONE;
      s = int'(c.proc_slot);
      case (c.opcode)
        OP_BLOCK: begin
          if (!waiting[s]) begin
            d = lookup_key(c.sem_key);
            if (d < 0) begin
              for (int i = 0; i < MaxProcs; i++)
                if (!sem_used[i] && d < 0) d = i;
            end else begin
              link_next[sem_tail[d]] = IdxW'(s);
              link_prev[s] = sem_tail[d];
              d = d + MaxProcs;
            end
            if (d < 0) begin
              r.status = ST_FULL;
            end else begin
              if (d >= MaxProcs) begin
                d = d - MaxProcs;
              end else begin
                sem_used[d] = 1;
                sem_key_tab[d] = c.sem_key;
                sem_head[d] = IdxW'(s);
              end
              sem_tail[d] = IdxW'(s);
              waiting[s] = 1;
              waits_on[s] = IdxW'(d);
              pid_of[s] = c.proc_pid;
              r.status = ST_OK;
            end
          end
        end
        OP_DEQUEUE, OP_PEEK: begin
          d = lookup_key(c.sem_key);
          if (d >= 0) begin
            r = granted(int'(sem_head[d]));
            if (c.opcode == OP_DEQUEUE) detach(int'(sem_head[d]));
          end
        end
        OP_RM_SLOT: begin
          if (waiting[s]) begin
            r = granted(s);
            detach(s);
          end
        end
        OP_RM_PID: begin
          for (int i = 0; i < MaxProcs; i++) begin
            if (waiting[i] && pid_of[i] == c.proc_pid && r.status != ST_OK) begin
              r = granted(i);
              detach(i);
            end
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want, checked);
      mismatches++;
    endtask

    task check_result(swq_out_t got);
      swq_out_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result", 32'(got.status), 32'd0);
        return;
      end
      want = pending_results.pop_front();
      if (got.status != want.status)
        report("status", 32'(got.status), 32'(want.status));
      if (got.out_slot != want.out_slot)
        report("out_slot", 32'(got.out_slot), 32'(want.out_slot));
      if (got.out_pid != want.out_pid)
        report("out_pid", 32'(got.out_pid), 32'(want.out_pid));
      if (got.out_key != want.out_key) report("out_key", got.out_key, want.out_key);
      if (want.status == ST_OK) ok_count++;
      checked++;
    endtask
  endclass

  wait_queue_scoreboard queue_sb;
  int unsigned cycles;
  logic [31:0] key_pool [8];
  logic [30:0] pid_pool [6];

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) queue_sb.check_result(result_o);
  end

  task idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk_i);
  endtask

  task issue(logic [2:0] op, logic [31:0] key, logic [4:0] slot, logic [30:0] pid,
             bit with_gaps);
    logic [95:0] junk;
    cmd_i = '{opcode: op, sem_key: key, proc_slot: slot, proc_pid: pid};
    start_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    queue_sb.note_transfer(cmd_i);
    @(negedge clk_i);
    junk = {$urandom, $urandom, $urandom};
    start_i = 1'b0;
    cmd_i = junk[$bits(swq_in_t)-1:0];
    if (with_gaps) idle_gap();
  endtask

  task random_item();
    int unsigned pick;
    logic [31:0] key;
    logic [30:0] pid;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 38) op = OP_BLOCK;
    else if (pick < 54) op = OP_DEQUEUE;
    else if (pick < 68) op = OP_RM_SLOT;
    else if (pick < 82) op = OP_RM_PID;
    else if (pick < 96) op = OP_PEEK;
    else op = 3'($urandom_range(5, 7));
    key = ($urandom_range(0, 15) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
    pid = ($urandom_range(0, 7) == 0) ? 31'($urandom) : pid_pool[$urandom_range(0, 5)];
    issue(op, key, 5'($urandom_range(0, 31)), pid, 1'b1);
  endtask

  initial begin
    queue_sb = new();
    cycles = 0;
    start_i = 1'b0;
    cmd_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    issue(OP_PEEK, 32'h0, 5'd0, 31'h0, 1'b0);
    issue(OP_DEQUEUE, 32'hFFFF_FFFF, 5'd0, 31'h0, 1'b0);
    issue(OP_RM_SLOT, 32'h0, 5'd31, 31'h0, 1'b0);
    issue(OP_RM_PID, 32'h0, 5'd0, 31'h7FFF_FFFF, 1'b0);
    issue(OP_BLOCK, 32'h0, 5'd0, 31'h0, 1'b0);
    issue(OP_BLOCK, 32'hFFFF_FFFF, 5'd31, 31'h7FFF_FFFF, 1'b0);
    issue(OP_BLOCK, 32'hFFFF_FFFF, 5'd31, 31'h1, 1'b0);
    issue(OP_BLOCK, 32'hFFFF_FFFF, 5'd5, 31'h7FFF_FFFF, 1'b0);
    issue(OP_BLOCK, 32'hFFFF_FFFF, 5'd2, 31'h1234, 1'b0);
    issue(OP_BLOCK, 32'hFFFF_FFFF, 5'd9, 31'h7FFF_FFFF, 1'b0);
    issue(OP_PEEK, 32'hFFFF_FFFF, 5'd0, 31'h0, 1'b0);
    issue(OP_RM_SLOT, 32'h0, 5'd2, 31'h0, 1'b0);
    issue(OP_RM_PID, 32'h0, 5'd0, 31'h7FFF_FFFF, 1'b0);
    issue(OP_DEQUEUE, 32'hFFFF_FFFF, 5'd0, 31'h0, 1'b0);
    issue(OP_DEQUEUE, 32'hFFFF_FFFF, 5'd0, 31'h0, 1'b0);
    issue(OP_DEQUEUE, 32'hFFFF_FFFF, 5'd0, 31'h0, 1'b0);
    issue(3'd5, 32'h0, 5'd0, 31'h0, 1'b0);
    issue(3'd6, 32'h0, 5'd0, 31'h0, 1'b0);
    issue(OP_NOP, 32'h0, 5'd0, 31'h0, 1'b0);
    issue(OP_DEQUEUE, 32'h0, 5'd0, 31'h0, 1'b0);
    issue(OP_PEEK, 32'h0, 5'd0, 31'h0, 1'b0);

    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 0; i < 6; i++) pid_pool[i] = 31'($urandom);
    pid_pool[0] = 31'h0;
    pid_pool[1] = 31'h7FFF_FFFF;

    for (int n = 0; n < RandomItems; n++) begin
      random_item();
      if (n % 400 == 399) begin
        for (int i = 0; i < 8; i++)
          if ($urandom_range(0, 1)) key_pool[i] = $urandom;
      end
    end

    while (queue_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d commands, %0d with a returned slot or a block granted",
             queue_sb.checked, queue_sb.ok_count);
    if (queue_sb.mismatches == 0 && queue_sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> semaphore_wait_queue_table_top.f
hdl/swq_pkg.sv
hdl/swq_front.sv
hdl/swq_back.sv
hdl/semaphore_wait_queue_table_top.sv
test/semaphore_wait_queue_table_top_tb.sv
